// ===== design/fisd_pkg.sv =====
// ----------------------------------------------------------------------------
// fisd_pkg
// Shared types, constants and helper functions for the reciprocal square
// root pipeline (binary64).
// ----------------------------------------------------------------------------
package fisd_pkg;

    // One pipeline lane: valid bit traveling with a binary64 word
    typedef struct packed {
        logic        valid;
        logic [63:0] bits;
    } t_lane;

    // Special-case flags that ride along an arithmetic pipeline
    typedef struct packed {
        logic sign;
        logic nan;
        logic inf;
        logic zero;
    } t_fsp;

    localparam logic [63:0] RSQRT_MAGIC = 64'h5fe6_eb50_c7b5_37a9;
    localparam logic [63:0] CANON_NAN   = 64'h7ff8_0000_0000_0000;
    localparam logic [63:0] ONE_P5_BITS = 64'h3ff8_0000_0000_0000;
    localparam logic [62:0] INF_MAG     = 63'h7ff0_0000_0000_0000;
    localparam logic [10:0] EXP_ONES    = 11'h7ff;

    // Pipeline depths of the arithmetic units
    localparam int MUL_LAT = 7;
    localparam int ADD_LAT = 6;

    // Leading zero count of a 53-bit significand (53 when zero)
    function automatic logic [5:0] f_lzc53(input logic [52:0] v);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (v[i]) begin
                n = 6'(52 - i);
            end
        end
        return n;
    endfunction

    // Leading zero count of a 56-bit word (56 when zero)
    function automatic logic [5:0] f_lzc56(input logic [55:0] v);
        logic [5:0] n;
        n = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (v[i]) begin
                n = 6'(55 - i);
            end
        end
        return n;
    endfunction

endpackage

// ===== design/fast_inverse_sqrt_double_core.sv =====
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_double_core
// Approximate 1/sqrt(x) on binary64: bit-trick seed plus one Newton step,
// each floating operation separately rounded to nearest even.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+---------------------
//   operand  | in        | i_valid / o_stall | i_number_bits [63:0]
//   result   | out       | o_valid / i_stall | o_rsqrt_bits  [63:0]
//
// One request enters per cycle while the pipeline is not stalled;
// the path is seed stage, two multipliers, adder, final multiplier.
// Reset is synchronous, active low, and clears only the valid bits.
// A stalled result freezes the whole pipeline in place; o_stall follows it.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_double_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_number_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_rsqrt_bits
);
    import fisd_pkg::*;

    localparam int Y_TAP1 = MUL_LAT;
    localparam int Y_TAP2 = MUL_LAT + ADD_LAT;

    logic        w_en;
    t_lane       w_x, w_half, w_p, w_q, w_one5, w_r, w_res;
    logic [63:0] w_y0, w_y1, w_y2;

    // Hold every stage while the result waits
    assign w_en    = !(w_res.valid && i_stall);
    assign o_stall = !w_en;
    assign w_x     = '{valid: i_valid, bits: i_number_bits};

    fisd_seed u_seed (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_x(w_x), .o_half(w_half), .o_y(w_y0)
    );

    // p = half * y
    fisd_fmul u_mul_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_half), .i_b(w_y0), .o_res(w_p)
    );

    fisd_delay #(.DEPTH(Y_TAP1)) u_dly_y1 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_y0), .o_d(w_y1)
    );

    // q = p * y
    fisd_fmul u_mul_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_p), .i_b(w_y1), .o_res(w_q)
    );

    // r = 1.5 - q
    assign w_one5 = '{valid: w_q.valid, bits: ONE_P5_BITS};

    fisd_fadd u_add_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_one5), .i_b({~w_q.bits[63], w_q.bits[62:0]}), .o_res(w_r)
    );

    fisd_delay #(.DEPTH(Y_TAP2)) u_dly_y2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_y1), .o_d(w_y2)
    );

    // result = y * r
    fisd_fmul u_mul_res (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_a(w_r), .i_b(w_y2), .o_res(w_res)
    );

    assign o_valid      = w_res.valid;
    assign o_rsqrt_bits = w_res.bits;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Stall toward the source only when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a waiting result");

    // Any NaN result leaves in canonical form
    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsqrt_bits[62:52] == EXP_ONES && o_rsqrt_bits[51:0] != 52'd0)
        |-> (o_rsqrt_bits == CANON_NAN))
        else $error("non-canonical NaN on result");

endmodule

// ===== design/fisd_delay.sv =====
// ----------------------------------------------------------------------------
// fisd_delay
// Shift line that holds a 64-bit word for a fixed number of pipeline steps.
// ----------------------------------------------------------------------------
module fisd_delay #(
    parameter int DEPTH = 7
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_d,
    output logic [63:0] o_d
);
    logic [63:0] r_tap [DEPTH];

    // Advance every tap when the pipeline moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

// ===== design/fisd_seed.sv =====
// ----------------------------------------------------------------------------
// fisd_seed
// First stage: forms x*0.5 exactly rounded and the integer-trick guess y.
// ----------------------------------------------------------------------------
module fisd_seed (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fisd_pkg::t_lane i_x,
    output fisd_pkg::t_lane o_half,
    output logic [63:0]     o_y
);
    import fisd_pkg::*;

    logic        r_valid;
    logic [63:0] r_half;
    logic [63:0] r_y;
    logic [63:0] n_half;
    logic [63:0] n_y;
    logic [10:0] s_exp;
    logic [52:0] s_q;
    logic        s_up;

    // Halve: drop exponent by one, or shift into subnormal range with RNE
    always_comb begin
        s_exp = i_x.bits[62:52];
        s_q   = {1'b0, i_x.bits[52:1]};
        s_up  = i_x.bits[0] & i_x.bits[1];
        if (s_exp == EXP_ONES) begin
            n_half = i_x.bits;
        end else if (s_exp >= 11'd2) begin
            n_half = i_x.bits - 64'h0010_0000_0000_0000;
        end else begin
            n_half = {i_x.bits[63], 10'd0, s_q + {52'd0, s_up}};
        end
        n_y = RSQRT_MAGIC - {i_x.bits[63], i_x.bits[63:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_x.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_half <= n_half;
            r_y    <= n_y;
        end
    end

    assign o_half = '{valid: r_valid, bits: r_half};
    assign o_y    = r_y;

endmodule

// ===== design/fisd_fmul.sv =====
// ----------------------------------------------------------------------------
// fisd_fmul
// Seven-stage binary64 multiplier, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fisd_fmul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fisd_pkg::t_lane i_a,
    input  logic [63:0]     i_b,
    output fisd_pkg::t_lane o_res
);
    import fisd_pkg::*;

    logic [6:0] r_valid;
    t_fsp       r_sp [6];

    // stage 1
    logic [52:0] r1_siga, r1_sigb;
    logic [5:0]  r1_lza, r1_lzb;
    logic [10:0] r1_ea, r1_eb;
    // stage 2
    logic [52:0] r2_siga, r2_sigb;
    logic signed [13:0] r2_ex;
    // stage 3
    logic [53:0] r3_hh;
    logic [52:0] r3_hl, r3_lh;
    logic [51:0] r3_ll;
    logic signed [13:0] r3_ex;
    // stage 4
    logic [105:0] r4_prod;
    logic signed [13:0] r4_ex;
    // stage 5
    logic [54:0] r5_w;
    logic [5:0]  r5_sh;
    logic [12:0] r5_eb;
    // stage 6
    logic [54:0] r6_w;
    logic [12:0] r6_eb;
    // stage 7
    logic [63:0] r7_bits;

    t_fsp        n_sp;
    logic [10:0] s_xa, s_xb;
    logic        s_nana, s_nanb, s_infa, s_infb, s_zra, s_zrb;
    logic [105:0] s_pn;
    logic signed [13:0] s_e;
    logic [13:0] s_shw;
    logic [5:0]  n_sh;
    logic [12:0] n_eb;
    logic [54:0] s_shr;
    logic        s_lost;
    logic [52:0] s_sig;
    logic        s_up;
    logic [64:0] s_field;
    logic [63:0] n_bits;

    // Unpack and classify both operands
    always_comb begin
        s_xa   = i_a.bits[62:52];
        s_xb   = i_b[62:52];
        s_nana = (s_xa == EXP_ONES) && (i_a.bits[51:0] != 52'd0);
        s_nanb = (s_xb == EXP_ONES) && (i_b[51:0] != 52'd0);
        s_infa = (s_xa == EXP_ONES) && (i_a.bits[51:0] == 52'd0);
        s_infb = (s_xb == EXP_ONES) && (i_b[51:0] == 52'd0);
        s_zra  = i_a.bits[62:0] == 63'd0;
        s_zrb  = i_b[62:0] == 63'd0;
        n_sp.sign = i_a.bits[63] ^ i_b[63];
        n_sp.nan  = s_nana | s_nanb | (s_infa & s_zrb) | (s_zra & s_infb);
        n_sp.inf  = s_infa | s_infb;
        n_sp.zero = s_zra | s_zrb;
    end

    // Stage 5 logic: normalize product, exponent, subnormal shift amount
    always_comb begin
        s_pn  = r4_prod[105] ? r4_prod : {r4_prod[104:0], 1'b0};
        s_e   = r4_ex - (r4_prod[105] ? 14'sd1022 : 14'sd1023);
        s_shw = 14'(14'sd1 - s_e);
        if (s_e < 14'sd1) begin
            n_sh = (s_shw > 14'd63) ? 6'd63 : s_shw[5:0];
            n_eb = 13'd0;
        end else begin
            n_sh = 6'd0;
            n_eb = 13'(s_e - 14'sd1);
        end
    end

    // Stage 6 logic: shift into subnormal range, keep sticky
    always_comb begin
        s_shr  = r5_w >> r5_sh;
        s_lost = |(r5_w & ~({55{1'b1}} << r5_sh));
    end

    // Stage 7 logic: round to nearest even and pack
    always_comb begin
        s_sig   = r6_w[54:2];
        s_up    = r6_w[1] & (r6_w[0] | s_sig[0]);
        s_field = {r6_eb, 52'd0} + {12'd0, s_sig} + {64'd0, s_up};
        if (r_sp[5].nan) begin
            n_bits = CANON_NAN;
        end else if (r_sp[5].inf) begin
            n_bits = {r_sp[5].sign, INF_MAG};
        end else if (r_sp[5].zero) begin
            n_bits = {r_sp[5].sign, 63'd0};
        end else if (s_field >= {2'd0, INF_MAG}) begin
            n_bits = {r_sp[5].sign, INF_MAG};
        end else begin
            n_bits = {r_sp[5].sign, s_field[62:0]};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[5:0], i_a.valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp[0] <= n_sp;
            for (int i = 1; i < 6; i++) begin
                r_sp[i] <= r_sp[i-1];
            end
            // stage 1
            r1_siga <= {s_xa != 11'd0, i_a.bits[51:0]};
            r1_sigb <= {s_xb != 11'd0, i_b[51:0]};
            r1_lza  <= f_lzc53({s_xa != 11'd0, i_a.bits[51:0]});
            r1_lzb  <= f_lzc53({s_xb != 11'd0, i_b[51:0]});
            r1_ea   <= (s_xa == 11'd0) ? 11'd1 : s_xa;
            r1_eb   <= (s_xb == 11'd0) ? 11'd1 : s_xb;
            // stage 2
            r2_siga <= r1_siga << r1_lza;
            r2_sigb <= r1_sigb << r1_lzb;
            r2_ex   <= $signed({3'd0, r1_ea} + {3'd0, r1_eb}
                               - {8'd0, r1_lza} - {8'd0, r1_lzb});
            // stage 3
            r3_hh <= r2_siga[52:26] * r2_sigb[52:26];
            r3_hl <= r2_siga[52:26] * r2_sigb[25:0];
            r3_lh <= r2_siga[25:0] * r2_sigb[52:26];
            r3_ll <= r2_siga[25:0] * r2_sigb[25:0];
            r3_ex <= r2_ex;
            // stage 4
            r4_prod <= {r3_hh, 52'd0}
                     + {26'd0, {1'b0, r3_hl} + {1'b0, r3_lh}, 26'd0}
                     + {54'd0, r3_ll};
            r4_ex   <= r3_ex;
            // stage 5
            r5_w  <= {s_pn[105:52], |s_pn[51:0]};
            r5_sh <= n_sh;
            r5_eb <= n_eb;
            // stage 6
            r6_w  <= {s_shr[54:1], s_shr[0] | s_lost};
            r6_eb <= r5_eb;
            // stage 7
            r7_bits <= n_bits;
        end
    end

    assign o_res = '{valid: r_valid[6], bits: r7_bits};

endmodule

// ===== design/fisd_fadd.sv =====
// ----------------------------------------------------------------------------
// fisd_fadd
// Six-stage binary64 adder, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module fisd_fadd (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fisd_pkg::t_lane i_a,
    input  logic [63:0]     i_b,
    output fisd_pkg::t_lane o_res
);
    import fisd_pkg::*;

    logic [5:0] r_valid;
    t_fsp       r_sp [5];
    logic [4:0] r_zsign;

    // stage 1
    logic [52:0] r1_sbig, r1_ssml;
    logic [10:0] r1_e;
    logic [5:0]  r1_d;
    logic        r1_sub;
    // stage 2
    logic [55:0] r2_a, r2_b;
    logic [10:0] r2_e;
    logic        r2_sub;
    // stage 3
    logic [56:0] r3_s;
    logic [10:0] r3_e;
    // stage 4
    logic [55:0] r4_s;
    logic [11:0] r4_e;
    logic [5:0]  r4_lsh;
    logic        r4_zero;
    // stage 5
    logic [55:0] r5_s;
    logic [11:0] r5_e;
    logic        r5_zero;
    // stage 6
    logic [63:0] r6_bits;

    logic [63:0] s_big, s_sml;
    logic [10:0] s_xbig, s_xsml, s_ebig, s_esml, s_dw;
    logic        s_nana, s_nanb, s_infa, s_infb;
    t_fsp        n_sp;
    logic [55:0] s_al;
    logic        s_lost;
    logic [55:0] n4_s;
    logic [11:0] n4_e, s_em1;
    logic [5:0]  s_lz, n4_lsh;
    logic [52:0] s_sig;
    logic        s_up;
    logic [64:0] s_field;
    logic [63:0] n_bits;

    // Classify and order operands by magnitude
    always_comb begin
        if (i_a.bits[62:0] >= i_b[62:0]) begin
            s_big = i_a.bits;
            s_sml = i_b;
        end else begin
            s_big = i_b;
            s_sml = i_a.bits;
        end
        s_xbig = s_big[62:52];
        s_xsml = s_sml[62:52];
        s_ebig = (s_xbig == 11'd0) ? 11'd1 : s_xbig;
        s_esml = (s_xsml == 11'd0) ? 11'd1 : s_xsml;
        s_dw   = s_ebig - s_esml;
        s_nana = (i_a.bits[62:52] == EXP_ONES) && (i_a.bits[51:0] != 52'd0);
        s_nanb = (i_b[62:52] == EXP_ONES) && (i_b[51:0] != 52'd0);
        s_infa = (i_a.bits[62:52] == EXP_ONES) && (i_a.bits[51:0] == 52'd0);
        s_infb = (i_b[62:52] == EXP_ONES) && (i_b[51:0] == 52'd0);
        n_sp.sign = s_big[63];
        n_sp.nan  = s_nana | s_nanb
                  | (s_infa & s_infb & (i_a.bits[63] ^ i_b[63]));
        n_sp.inf  = s_infa | s_infb;
        n_sp.zero = 1'b0;
    end

    // Stage 2 logic: align smaller operand, fold lost bits into sticky
    always_comb begin
        s_al   = {r1_ssml, 3'd0} >> r1_d;
        s_lost = |({r1_ssml, 3'd0} & ~({56{1'b1}} << r1_d));
    end

    // Stage 4 logic: handle carry out, pick left shift for cancellation
    always_comb begin
        s_lz  = f_lzc56(r3_s[55:0]);
        s_em1 = {1'b0, r3_e} - 12'd1;
        if (r3_s[56]) begin
            n4_s   = {r3_s[56:2], r3_s[1] | r3_s[0]};
            n4_e   = {1'b0, r3_e} + 12'd1;
            n4_lsh = 6'd0;
        end else begin
            n4_s   = r3_s[55:0];
            n4_e   = {1'b0, r3_e};
            n4_lsh = ({6'd0, s_lz} > s_em1) ? s_em1[5:0] : s_lz;
        end
    end

    // Stage 6 logic: round to nearest even and pack
    always_comb begin
        s_sig   = r5_s[55:3];
        s_up    = r5_s[2] & ((|r5_s[1:0]) | s_sig[0]);
        s_field = {1'b0, r5_e - 12'd1, 52'd0} + {12'd0, s_sig} + {64'd0, s_up};
        if (r_sp[4].nan) begin
            n_bits = CANON_NAN;
        end else if (r_sp[4].inf) begin
            n_bits = {r_sp[4].sign, INF_MAG};
        end else if (r5_zero) begin
            n_bits = {r_zsign[4], 63'd0};
        end else if (s_field >= {2'd0, INF_MAG}) begin
            n_bits = {r_sp[4].sign, INF_MAG};
        end else begin
            n_bits = {r_sp[4].sign, s_field[62:0]};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_a.valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp[0]  <= n_sp;
            r_zsign  <= {r_zsign[3:0], i_a.bits[63] & i_b[63]};
            for (int i = 1; i < 5; i++) begin
                r_sp[i] <= r_sp[i-1];
            end
            // stage 1
            r1_sbig <= {s_xbig != 11'd0, s_big[51:0]};
            r1_ssml <= {s_xsml != 11'd0, s_sml[51:0]};
            r1_e    <= s_ebig;
            r1_d    <= (s_dw > 11'd63) ? 6'd63 : s_dw[5:0];
            r1_sub  <= i_a.bits[63] ^ i_b[63];
            // stage 2
            r2_a   <= {r1_sbig, 3'd0};
            r2_b   <= {s_al[55:1], s_al[0] | s_lost};
            r2_e   <= r1_e;
            r2_sub <= r1_sub;
            // stage 3
            r3_s <= r2_sub ? ({1'b0, r2_a} - {1'b0, r2_b})
                           : ({1'b0, r2_a} + {1'b0, r2_b});
            r3_e <= r2_e;
            // stage 4
            r4_s    <= n4_s;
            r4_e    <= n4_e;
            r4_lsh  <= n4_lsh;
            r4_zero <= r3_s == 57'd0;
            // stage 5
            r5_s    <= r4_s << r4_lsh;
            r5_e    <= r4_e - {6'd0, r4_lsh};
            r5_zero <= r4_zero;
            // stage 6
            r6_bits <= n_bits;
        end
    end

    assign o_res = '{valid: r_valid[5], bits: r6_bits};

endmodule

// ===== sim/tb_fast_inverse_sqrt_double_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fast_inverse_sqrt_double_core
// Self-checking bench for the binary64 reciprocal square root pipeline.
// Directed operands cover zeros, infinities, NaNs, subnormals, negatives and
// range limits. Random operands follow, with random gaps on the operand side
// and random stalls on the result side. One long result stall fills the
// pipeline. Results are checked in order against a predictor built on real
// arithmetic.
// ----------------------------------------------------------------------------
module tb_fast_inverse_sqrt_double_core;
    import fisd_pkg::*;

    localparam int N_RANDOM     = 1030;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_GAP      = 18;

    // Seed plus one Newton step, each operation rounded on its own
    function automatic logic [63:0] rsqrt_approx(input logic [63:0] xb);
        logic signed [63:0] shifted;
        logic [63:0]        seed_bits;
        logic [63:0]        rb;
        real                x, y, half, p, q, r, res;
        shifted   = $signed(xb) >>> 1;
        seed_bits = RSQRT_MAGIC - shifted;
        x    = $bitstoreal(xb);
        y    = $bitstoreal(seed_bits);
        half = x * 0.5;
        p    = half * y;
        q    = p * y;
        r    = 1.5 - q;
        res  = y * r;
        rb   = $realtobits(res);
        // Any NaN comes out in canonical quiet form
        if (rb[62:52] == EXP_ONES && rb[51:0] != 52'd0) begin
            rb = CANON_NAN;
        end
        return rb;
    endfunction

    class rsqrt_scoreboard;
        logic [63:0] pending_q[$];
        logic [63:0] operand_q[$];
        int          n_errors;
        int          n_checked;

        function void note_request(input logic [63:0] xb);
            pending_q.push_back(rsqrt_approx(xb));
            operand_q.push_back(xb);
        endfunction

        function void check_result(input logic [63:0] got);
            logic [63:0] want;
            logic [63:0] xb;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                n_errors++;
                return;
            end
            want = pending_q.pop_front();
            xb   = operand_q.pop_front();
            n_checked++;
            if (got !== want) begin
                $display("%0t: rsqrt_bits mismatch for operand %h: expected %h, actual %h",
                         $realtime, xb, want, got);
                n_errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_number_bits;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_rsqrt_bits;

    rsqrt_scoreboard sb;
    bit              sending_done;
    int              n_sent;

    fast_inverse_sqrt_double_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_number_bits (i_number_bits),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rsqrt_bits  (o_rsqrt_bits)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Pick a random operand, weighted toward the useful positive range
    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0, 1, 2, 3: begin
                v[63]    = 1'b0;
                v[62:52] = 11'($urandom_range(1023 - 40, 1023 + 40));
            end
            4: v[62:52] = 11'd0;
            5: begin
                v[63]    = 1'b1;
                v[62:52] = 11'($urandom_range(1000, 1050));
            end
            6: v[62:52] = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(1, 20))
                                                       : 11'($urandom_range(2030, 2046));
            7: begin
                v[62:52] = EXP_ONES;
                if ($urandom_range(0, 2) == 0) begin
                    v[51:0] = 52'd0;
                end
            end
            8: v[62:0] = 63'd0;
            default: ;
        endcase
        return v;
    endfunction

    // Offer one request and hold it until taken, then wait the gap
    task automatic send_request(input logic [63:0] v, input int gap);
        i_valid       <= 1'b1;
        i_number_bits <= v;
        forever begin
            @(negedge i_clk);
            if (!o_stall) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        sb.note_request(v);
        n_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Draw a gap: runs of back-to-back traffic mixed with idling
    function automatic int draw_gap(input int idx);
        if (idx >= 150 && idx < 450) return 0;
        if ((idx / 100) % 3 == 2) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Operand side
    initial begin
        logic [63:0] directed[$];
        sb            = new();
        sending_done  = 1'b0;
        n_sent        = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_number_bits = 64'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                     64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
                     64'h7ff8_0000_0000_0000, 64'h7ff0_0000_0000_0001,
                     64'hfff8_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
                     64'h7fff_ffff_ffff_ffff, 64'h3ff0_0000_0000_0000,
                     64'h4010_0000_0000_0000, 64'h3fd0_0000_0000_0000,
                     64'h4000_0000_0000_0000, 64'h0000_0000_0000_0001,
                     64'h000f_ffff_ffff_ffff, 64'h0010_0000_0000_0000,
                     64'h7fef_ffff_ffff_ffff, 64'hbff0_0000_0000_0000,
                     64'h8000_0000_0000_0001, 64'hffef_ffff_ffff_ffff,
                     64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa};
        foreach (directed[k]) begin
            send_request(directed[k], $urandom_range(0, 3));
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            send_request(random_operand(), draw_gap(k));
        end
        i_valid      <= 1'b0;
        sending_done  = 1'b1;
    end

    // Result side: random stalls, one long hold-off, check each result
    initial begin
        int  w;
        bit  held;
        held    = 1'b0;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && sb.n_checked >= 180) begin
                held = 1'b1;
                w    = HOLD_CYCLES;
            end else if ((sb.n_checked / 120) % 3 == 1) begin
                w = 0;
            end else begin
                w = $urandom_range(0, MAX_GAP);
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            forever begin
                @(negedge i_clk);
                if (o_valid && !i_stall) begin
                    sb.check_result(o_rsqrt_bits);
                    @(posedge i_clk);
                    break;
                end
                @(posedge i_clk);
            end
        end
    end

    // Drain and report
    initial begin
        @(posedge i_clk iff sending_done);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fisd_pkg.sv
design/fisd_delay.sv
design/fisd_seed.sv
design/fisd_fmul.sv
design/fisd_fadd.sv
design/fast_inverse_sqrt_double_core.sv
sim/tb_fast_inverse_sqrt_double_core.sv
